### hw/rtl/sdc_pkg.sv
// ----------------------------------------------------------------------------
// sdc_pkg
// Shared types, sizes and boundary tables for the sphere direction coverage
// block: payload structs, squared Q1.15 latitude and Q1.15 longitude boundary constants.
// ----------------------------------------------------------------------------
package sdc_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int DIFF_WIDTH   = SAMPLE_WIDTH + 1;
    localparam int ZZ_W         = 2 * SAMPLE_WIDTH;
    localparam int N2_W         = 2 * SAMPLE_WIDTH + 2;

    localparam int LAT_BINS   = 18;
    localparam int LON_BINS   = 32;
    localparam int TOTAL_BINS = LAT_BINS * LON_BINS;
    localparam int BIN_W      = 5;
    localparam int COUNT_W    = 10;
    localparam int COV_W      = 14;
    localparam int ROW_AW     = $clog2(LAT_BINS);
    localparam int LON_AW     = $clog2(LON_BINS);

    // positive latitude boundaries, mirrored for the southern half
    localparam int LAT_STEPS   = (LAT_BINS - 1) / 2;
    localparam int LON_QUARTER = LON_BINS / 4;
    localparam int TAN_N       = LON_BINS / 8;

    // shared multiplier operand widths
    localparam int MUL_A_W    = 30;
    localparam int MUL_B_W    = 17;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int LAT_CMP_W  = PROD_W + MUL_B_W;
    localparam int LON_CMP_W  = 32;
    localparam int Q_SHIFT    = 15;
    localparam int Q2_SHIFT   = 2 * Q_SHIFT;

    // floor(count * 10000 / TOTAL_BINS) = (count * COV_MULT) >> COV_SHIFT
    localparam int                   COV_SHIFT = 20;
    localparam logic [MUL_A_W-1:0]   COV_MULT  = 30'd18204445;

    // squares of the Q1.15 sines of the positive latitude boundaries
    localparam logic [MUL_A_W-1:0] LAT_SIN_SQ [LAT_STEPS] = '{
        30'd32376100,  30'd125596849, 30'd268435456, 30'd443692096,
        30'd630110404, 30'd805310884, 30'd948208849, 30'd1041417441
    };

    // unsigned Q1.15 tangents of the first-octant longitude boundaries
    localparam logic [15:0] LON_TAN [TAN_N] = '{
        16'd6518, 16'd13573, 16'd21895, 16'd32768
    };

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    typedef struct packed {
        logic                           action;
        logic signed [SAMPLE_WIDTH-1:0] mag_x;
        logic signed [SAMPLE_WIDTH-1:0] mag_y;
        logic signed [SAMPLE_WIDTH-1:0] mag_z;
    } t_in_item;

    typedef struct packed {
        logic [BIN_W-1:0]   lat_bin;
        logic [BIN_W-1:0]   lon_bin;
        logic               newly_occupied;
        logic [COUNT_W-1:0] occupied_count;
        logic [COV_W-1:0]   coverage_centipercent;
    } t_out_item;

endpackage

### hw/rtl/sdc_ram.sv
// ----------------------------------------------------------------------------
// sdc_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module sdc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 18
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/sphere_direction_coverage.sv
// ----------------------------------------------------------------------------
// sphere_direction_coverage: bins magnetometer directions, tracks coverage
// Flow: a sample or clear is taken only in the idle state, so a new item waits
//   until the last result has gone to the output register; a sample issues all
//   its products to the shared 30x17 multiplier, then does the map read-modify-write
// Reset: synchronous, clears offsets, count and the per-row map valid bits
// ----------------------------------------------------------------------------
module sphere_direction_coverage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  sdc_pkg::t_in_item             i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output sdc_pkg::t_out_item            o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sdc_pkg::APB_AW-1:0]    paddr,
    input  logic [sdc_pkg::APB_DW-1:0]    pwdata,
    output logic [sdc_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    import sdc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_CALC, S_LOOK, S_RMW, S_COV, S_FIN
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE, OP_SQ_Z, OP_SQ_XY, OP_LON, OP_LAT_LO, OP_LAT_HI, OP_COV
    } t_op;

    localparam logic [1:0] REG_OFFSET_X = 2'd0;
    localparam logic [1:0] REG_OFFSET_Y = 2'd1;
    localparam logic [1:0] REG_OFFSET_Z = 2'd2;

    localparam int STEP_SQ_Z = 0;
    localparam int STEP_SQ_X = 1;
    localparam int STEP_SQ_Y = 2;
    localparam int STEP_LON0 = 3;
    localparam int STEP_LAT0 = STEP_LON0 + LON_QUARTER - 1;
    localparam int STEP_DONE = STEP_LAT0 + 2 * LAT_STEPS;
    localparam int STEP_W    = $clog2(STEP_DONE + 1);
    localparam int LON_J_W   = $clog2(LON_QUARTER);
    localparam int TAN_AW    = $clog2(TAN_N);
    localparam int LAT_M_W   = $clog2(LAT_STEPS);
    localparam int LAT_CNT_W = $clog2(LAT_STEPS + 1);

    t_state                 r_state;
    t_op                    r_tag;
    logic [LON_J_W-1:0]     r_tag_j;
    logic [STEP_W-1:0]      r_step;
    logic [SAMPLE_WIDTH-1:0] r_off_x, r_off_y, r_off_z;
    logic [DIFF_WIDTH-1:0]  r_x, r_y, r_z;
    logic [N2_W-1:0]        r_n2;
    logic [ZZ_W-1:0]        r_zz;
    logic [PROD_W-1:0]      r_prod;
    logic [PROD_W-1:0]      r_acc;
    logic [LAT_CNT_W-1:0]   r_lat_cnt;
    logic [LON_J_W-1:0]     r_lon_cnt;
    logic [BIN_W-1:0]       r_lat, r_lon;
    logic                   r_fresh;
    logic [COUNT_W-1:0]     r_count;
    logic [LAT_BINS-1:0]    r_row_valid;
    logic                   r_out_valid;
    t_out_item              r_out;

    // magnitudes and signs of the offset-corrected sample
    logic [DIFF_WIDTH-1:0]   x_neg_v, y_neg_v, z_neg_v;
    logic [SAMPLE_WIDTH-1:0] x_abs, y_abs, z_abs;
    logic                    x_neg, y_neg, z_neg, x_zero, y_zero, z_zero;

    assign x_neg   = r_x[DIFF_WIDTH-1];
    assign y_neg   = r_y[DIFF_WIDTH-1];
    assign z_neg   = r_z[DIFF_WIDTH-1];
    assign x_zero  = (r_x == '0);
    assign y_zero  = (r_y == '0);
    assign z_zero  = (r_z == '0);
    assign x_neg_v = -r_x;
    assign y_neg_v = -r_y;
    assign z_neg_v = -r_z;
    assign x_abs   = x_neg ? x_neg_v[SAMPLE_WIDTH-1:0] : r_x[SAMPLE_WIDTH-1:0];
    assign y_abs   = y_neg ? y_neg_v[SAMPLE_WIDTH-1:0] : r_y[SAMPLE_WIDTH-1:0];
    assign z_abs   = z_neg ? z_neg_v[SAMPLE_WIDTH-1:0] : r_z[SAMPLE_WIDTH-1:0];

    // operation issue for the shared multiplier
    t_op                 op;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [PROD_W-1:0]   mul_p;
    logic [LON_J_W-1:0]  lon_j;
    logic [TAN_AW-1:0]   tan_idx;
    logic [STEP_W-1:0]   lat_off;
    logic [LAT_M_W-1:0]  lat_m;

    assign lon_j   = LON_J_W'(r_step - STEP_W'(STEP_LON0 - 1));
    assign tan_idx = (lon_j <= LON_J_W'(TAN_N)) ? TAN_AW'(lon_j - 1'b1)
                                                 : TAN_AW'(LON_J_W'(LON_QUARTER - 1) - lon_j);
    assign lat_off = r_step - STEP_W'(STEP_LAT0);
    assign lat_m   = lat_off[LAT_M_W:1];

    always_comb begin
        op    = OP_NONE;
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_CALC: begin
                if (r_step == STEP_W'(STEP_SQ_Z)) begin
                    op    = OP_SQ_Z;
                    mul_a = MUL_A_W'(z_abs);
                    mul_b = MUL_B_W'(z_abs);
                end else if (r_step == STEP_W'(STEP_SQ_X)) begin
                    op    = OP_SQ_XY;
                    mul_a = MUL_A_W'(x_abs);
                    mul_b = MUL_B_W'(x_abs);
                end else if (r_step == STEP_W'(STEP_SQ_Y)) begin
                    op    = OP_SQ_XY;
                    mul_a = MUL_A_W'(y_abs);
                    mul_b = MUL_B_W'(y_abs);
                end else if (r_step < STEP_W'(STEP_LAT0)) begin
                    // low boundaries scale x, mirrored ones scale y
                    op    = OP_LON;
                    mul_a = MUL_A_W'(LON_TAN[tan_idx]);
                    mul_b = (lon_j <= LON_J_W'(TAN_N)) ? MUL_B_W'(x_abs) : MUL_B_W'(y_abs);
                end else if (r_step < STEP_W'(STEP_DONE)) begin
                    mul_a = LAT_SIN_SQ[lat_m];
                    if (lat_off[0]) begin
                        op    = OP_LAT_HI;
                        mul_b = r_n2[N2_W-1:MUL_B_W];
                    end else begin
                        op    = OP_LAT_LO;
                        mul_b = r_n2[MUL_B_W-1:0];
                    end
                end
            end
            S_COV: begin
                op    = OP_COV;
                mul_a = COV_MULT;
                mul_b = MUL_B_W'(r_count);
            end
            default: begin
                op = OP_NONE;
            end
        endcase
    end

    assign mul_p = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

    // latitude test: z^2 * 2^30 against sin^2 * n2, n2 product done in halves
    logic [LAT_CMP_W-1:0] lat_full, zz_scaled;
    logic                 lat_up;

    assign lat_full  = {{MUL_B_W{1'b0}}, r_acc} + {r_prod, {MUL_B_W{1'b0}}};
    assign zz_scaled = {{(LAT_CMP_W - ZZ_W - Q2_SHIFT){1'b0}}, r_zz, {Q2_SHIFT{1'b0}}};
    assign lat_up    = z_neg ? (zz_scaled <= lat_full) : (zz_scaled >= lat_full);

    // longitude test against one octant boundary
    logic [LON_CMP_W-1:0] lon_lhs, lon_rhs, b_scaled, a_scaled;
    logic                 lon_strict, lon_up;

    assign a_scaled   = {{(LON_CMP_W - SAMPLE_WIDTH - Q_SHIFT){1'b0}}, x_abs, {Q_SHIFT{1'b0}}};
    assign b_scaled   = {{(LON_CMP_W - SAMPLE_WIDTH - Q_SHIFT){1'b0}}, y_abs, {Q_SHIFT{1'b0}}};
    assign lon_lhs    = (r_tag_j <= LON_J_W'(TAN_N)) ? b_scaled : r_prod[LON_CMP_W-1:0];
    assign lon_rhs    = (r_tag_j <= LON_J_W'(TAN_N)) ? r_prod[LON_CMP_W-1:0] : a_scaled;
    assign lon_strict = x_neg ^ y_neg;
    assign lon_up     = lon_strict ? (lon_lhs > lon_rhs) : (lon_lhs >= lon_rhs);

    // final bins from the boundary counts
    logic [BIN_W-1:0] lat_calc, lon_calc;

    always_comb begin
        if (z_zero) begin
            lat_calc = BIN_W'(LAT_BINS / 2);
        end else if (z_neg) begin
            lat_calc = BIN_W'(r_lat_cnt);
        end else begin
            lat_calc = BIN_W'(LAT_BINS / 2) + BIN_W'(r_lat_cnt);
        end

        if (y_zero) begin
            lon_calc = x_neg ? BIN_W'(LON_BINS - 1) : BIN_W'(LON_BINS / 2);
        end else if (x_zero) begin
            lon_calc = y_neg ? BIN_W'(LON_BINS / 2 - LON_QUARTER)
                             : BIN_W'(LON_BINS / 2 + LON_QUARTER);
        end else begin
            case ({x_neg, y_neg})
                2'b00:   lon_calc = BIN_W'(LON_BINS / 2) + BIN_W'(r_lon_cnt);
                2'b10:   lon_calc = BIN_W'(LON_BINS - 1) - BIN_W'(r_lon_cnt);
                2'b11:   lon_calc = BIN_W'(r_lon_cnt);
                default: lon_calc = BIN_W'(LON_BINS / 2 - 1) - BIN_W'(r_lon_cnt);
            endcase
        end
    end

    // occupancy map, one row per latitude bin; a row not yet valid reads as empty
    logic                ram_we;
    logic [LON_BINS-1:0] ram_rdata, row_bits, ram_wdata;
    logic                hit;

    assign row_bits  = r_row_valid[r_lat[ROW_AW-1:0]] ? ram_rdata : '0;
    assign hit       = row_bits[r_lon[LON_AW-1:0]];
    assign ram_we    = (r_state == S_RMW) && !hit;
    assign ram_wdata = row_bits | (LON_BINS'(1) << r_lon[LON_AW-1:0]);

    sdc_ram #(
        .WIDTH (LON_BINS),
        .DEPTH (LAT_BINS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_lat[ROW_AW-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (lat_calc[ROW_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    logic in_xfer, out_free, cfg_we;

    assign in_xfer  = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_out_ready;
    assign cfg_we   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tag       <= OP_NONE;
            r_step      <= '0;
            r_off_x     <= '0;
            r_off_y     <= '0;
            r_off_z     <= '0;
            r_count     <= '0;
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (paddr[3:2])
                    REG_OFFSET_X: r_off_x <= pwdata[SAMPLE_WIDTH-1:0];
                    REG_OFFSET_Y: r_off_y <= pwdata[SAMPLE_WIDTH-1:0];
                    REG_OFFSET_Z: r_off_z <= pwdata[SAMPLE_WIDTH-1:0];
                    default: ;
                endcase
            end

            // consume the product issued in the cycle before
            r_tag   <= op;
            r_tag_j <= lon_j;
            if (op != OP_NONE) begin
                r_prod <= mul_p;
            end
            case (r_tag)
                OP_SQ_Z: begin
                    r_zz <= r_prod[ZZ_W-1:0];
                    r_n2 <= N2_W'(r_prod[ZZ_W-1:0]);
                end
                OP_SQ_XY: r_n2 <= r_n2 + N2_W'(r_prod[ZZ_W-1:0]);
                OP_LON: begin
                    if (lon_up) begin
                        r_lon_cnt <= r_lon_cnt + 1'b1;
                    end
                end
                OP_LAT_LO: r_acc <= r_prod;
                OP_LAT_HI: begin
                    if (!z_zero && lat_up) begin
                        r_lat_cnt <= r_lat_cnt + 1'b1;
                    end
                end
                default: ;
            endcase

            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (i_in.action) begin
                            r_row_valid <= '0;
                            r_count     <= '0;
                            r_lat       <= '0;
                            r_lon       <= '0;
                            r_fresh     <= 1'b0;
                            r_state     <= S_COV;
                        end else begin
                            r_x       <= {i_in.mag_x[SAMPLE_WIDTH-1], i_in.mag_x}
                                       - {r_off_x[SAMPLE_WIDTH-1], r_off_x};
                            r_y       <= {i_in.mag_y[SAMPLE_WIDTH-1], i_in.mag_y}
                                       - {r_off_y[SAMPLE_WIDTH-1], r_off_y};
                            r_z       <= {i_in.mag_z[SAMPLE_WIDTH-1], i_in.mag_z}
                                       - {r_off_z[SAMPLE_WIDTH-1], r_off_z};
                            r_step    <= '0;
                            r_lat_cnt <= '0;
                            r_lon_cnt <= '0;
                            r_state   <= S_CALC;
                        end
                    end
                end
                S_CALC: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(STEP_DONE)) begin
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_lat   <= lat_calc;
                    r_lon   <= lon_calc;
                    r_state <= S_RMW;
                end
                S_RMW: begin
                    r_fresh <= !hit;
                    if (!hit) begin
                        r_row_valid[r_lat[ROW_AW-1:0]] <= 1'b1;
                        r_count <= r_count + 1'b1;
                    end
                    r_state <= S_COV;
                end
                S_COV: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out.lat_bin               <= r_lat;
                        r_out.lon_bin               <= r_lon;
                        r_out.newly_occupied        <= r_fresh;
                        r_out.occupied_count        <= r_count;
                        r_out.coverage_centipercent <= r_prod[COV_SHIFT +: COV_W];
                        r_state                     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_OFFSET_X: prdata = {{(APB_DW - SAMPLE_WIDTH){r_off_x[SAMPLE_WIDTH-1]}}, r_off_x};
            REG_OFFSET_Y: prdata = {{(APB_DW - SAMPLE_WIDTH){r_off_y[SAMPLE_WIDTH-1]}}, r_off_y};
            REG_OFFSET_Z: prdata = {{(APB_DW - SAMPLE_WIDTH){r_off_z[SAMPLE_WIDTH-1]}}, r_off_z};
            default:      prdata = '0;
        endcase
    end

    assign pready      = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### test/tb_sphere_direction_coverage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sphere_direction_coverage
// Self-checking bench for the sphere direction coverage block. Samples and
// clears go in over valid/ready with random bursts, gaps and output stalls.
// The hard-iron offsets are programmed over APB, and every result is compared
// with a bit-exact predictor of the bin lookup, the occupancy map and the
// coverage figure.
// ----------------------------------------------------------------------------
module tb_sphere_direction_coverage;
    import sdc_pkg::*;

    localparam int   CYCLE_LIMIT  = 600000;
    localparam int   DRAIN_CYCLES = 40;
    localparam int   REPORT_CAP   = 50;
    localparam logic ACT_SAMPLE   = 1'b0;
    localparam logic ACT_CLEAR    = 1'b1;
    localparam logic [APB_AW-1:0] REG_OFFSET_X = 4'h0;
    localparam logic [APB_AW-1:0] REG_OFFSET_Y = 4'h4;
    localparam logic [APB_AW-1:0] REG_OFFSET_Z = 4'h8;
    localparam real  PI = 3.14159265358979323846;

    // q1.15 sines of the latitude boundaries, south to north
    localparam int BOUND_SIN [LAT_BINS-1] = '{
        -32271, -30793, -28378, -25102, -21064, -16384, -11207, -5690, 0,
        5690, 11207, 16384, 21064, 25102, 28378, 30793, 32271
    };
    // q1.15 tangents of the first-octant longitude boundaries
    localparam int BOUND_TAN [LON_BINS/8] = '{6518, 13573, 21895, 32768};

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    t_in_item          in_item   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    t_out_item         out_item;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [APB_AW-1:0] paddr     = '0;
    logic [APB_DW-1:0] pwdata    = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // predictor state
    logic signed [SAMPLE_WIDTH-1:0] off_x = '0;
    logic signed [SAMPLE_WIDTH-1:0] off_y = '0;
    logic signed [SAMPLE_WIDTH-1:0] off_z = '0;
    bit          occ_map [TOTAL_BINS];
    int unsigned occ_count  = 0;
    int unsigned peak_count = 0;

    t_out_item   expected_bins [$];

    // traffic shaping
    bit          tx_bursty   = 1'b1;
    bit          rx_stalls   = 1'b1;
    int          burst_left  = 0;
    int          rx_hold_req = 0;
    int          hold_left   = 0;
    int          stall_left  = 0;

    int unsigned cycle_count  = 0;
    int unsigned n_items      = 0;
    int unsigned n_clears     = 0;
    int unsigned n_writes     = 0;
    int unsigned n_checked    = 0;
    int unsigned field_errors = 0;
    int unsigned stray_count  = 0;

    sphere_direction_coverage i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic int unsigned lat_band(input longint z, input longint unsigned n2);
        longint unsigned za, sa;
        logic [127:0]    zz_scaled, ss_n2;
        int unsigned     cnt;
        bit              up;
        za = (z < 0) ? -z : z;
        zz_scaled = 128'(za * za) << 30;
        cnt = 0;
        for (int k = 0; k < LAT_BINS - 1; k++) begin
            sa = (BOUND_SIN[k] < 0) ? -BOUND_SIN[k] : BOUND_SIN[k];
            ss_n2 = 128'(sa * sa) * 128'(n2);
            if (BOUND_SIN[k] < 0)
                up = (z >= 0) || (zz_scaled <= ss_n2);
            else if (BOUND_SIN[k] == 0)
                up = (z >= 0);
            else
                up = (z > 0) && (zz_scaled >= ss_n2);
            if (up) cnt++;
        end
        if (cnt > LAT_BINS - 1) cnt = LAT_BINS - 1;
        return cnt;
    endfunction

    // fine boundaries passed by atan(b/a) within one quadrant
    function automatic int unsigned octant_steps(input longint unsigned a,
                                                 input longint unsigned b, input bit strict);
        longint unsigned lhs, rhs;
        int unsigned     cnt;
        cnt = 0;
        for (int j = 1; j < LON_QUARTER; j++) begin
            if (2 * j <= LON_QUARTER) begin
                lhs = b * 32768;
                rhs = longint'(BOUND_TAN[j-1]) * a;
            end else begin
                lhs = longint'(BOUND_TAN[LON_QUARTER-j-1]) * b;
                rhs = a * 32768;
            end
            if (strict ? (lhs > rhs) : (lhs >= rhs)) cnt++;
        end
        return cnt;
    endfunction

    function automatic int unsigned lon_sector(input longint x, input longint y);
        longint unsigned xa, ya;
        xa = (x < 0) ? -x : x;
        ya = (y < 0) ? -y : y;
        if (y == 0) return (x < 0) ? LON_BINS - 1 : LON_BINS / 2;
        if (x == 0) return (y > 0) ? LON_BINS / 2 + LON_QUARTER : LON_BINS / 2 - LON_QUARTER;
        if (x > 0 && y > 0) return LON_BINS / 2 + octant_steps(xa, ya, 1'b0);
        if (x < 0 && y > 0) return LON_BINS - 1 - octant_steps(xa, ya, 1'b1);
        if (x < 0) return octant_steps(xa, ya, 1'b0);
        return LON_BINS / 2 - 1 - octant_steps(xa, ya, 1'b1);
    endfunction

    function automatic void locate_bin(input t_in_item it, output int unsigned lat,
                                       output int unsigned lon);
        longint          x, y, z;
        longint unsigned n2;
        x = longint'($signed(it.mag_x)) - longint'(off_x);
        y = longint'($signed(it.mag_y)) - longint'(off_y);
        z = longint'($signed(it.mag_z)) - longint'(off_z);
        if (x == 0 && y == 0 && z == 0) begin
            lat = LAT_BINS / 2;
            lon = LON_BINS / 2;
        end else begin
            n2  = x * x + y * y + z * z;
            lat = lat_band(z, n2);
            lon = lon_sector(x, y);
        end
        if (lat > LAT_BINS - 1) lat = LAT_BINS - 1;
        if (lon > LON_BINS - 1) lon = LON_BINS - 1;
    endfunction

    function automatic t_out_item predict_bin(input t_in_item it);
        t_out_item   r;
        int unsigned lat, lon, idx, cov;
        r = '0;
        if (it.action == ACT_CLEAR) begin
            foreach (occ_map[i]) occ_map[i] = 1'b0;
            occ_count = 0;
            return r;
        end
        locate_bin(it, lat, lon);
        idx = lat * LON_BINS + lon;
        if (!occ_map[idx]) begin
            occ_map[idx] = 1'b1;
            occ_count++;
            r.newly_occupied = 1'b1;
        end
        if (occ_count > peak_count) peak_count = occ_count;
        cov = occ_count * 10000 / TOTAL_BINS;
        r.lat_bin               = lat[BIN_W-1:0];
        r.lon_bin               = lon[BIN_W-1:0];
        r.occupied_count        = occ_count[COUNT_W-1:0];
        r.coverage_centipercent = cov[COV_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // item builders
    // ------------------------------------------------------------------
    function automatic t_in_item make_sample(input int x, input int y, input int z);
        t_in_item it;
        it.action = ACT_SAMPLE;
        it.mag_x  = x[SAMPLE_WIDTH-1:0];
        it.mag_y  = y[SAMPLE_WIDTH-1:0];
        it.mag_z  = z[SAMPLE_WIDTH-1:0];
        return it;
    endfunction

    // raw reading that gives difference d, saturated to the sample range
    function automatic int raw_for(input logic signed [SAMPLE_WIDTH-1:0] off, input longint d);
        longint v;
        v = longint'(off) + d;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return int'(v);
    endfunction

    function automatic real rand01();
        return $itor($urandom_range(0, 1000000)) / 1000000.0;
    endfunction

    function automatic t_in_item direction_sample(input real theta, input real phi,
                                                  input real radius);
        longint dx, dy, dz;
        dx = $rtoi(radius * $cos(theta) * $cos(phi));
        dy = $rtoi(radius * $cos(theta) * $sin(phi));
        dz = $rtoi(radius * $sin(theta));
        return make_sample(raw_for(off_x, dx), raw_for(off_y, dy), raw_for(off_z, dz));
    endfunction

    function automatic int rand_sign();
        return ($urandom_range(0, 1) == 1) ? 1 : -1;
    endfunction

    function automatic t_in_item random_sample();
        int     kind, mask, m;
        longint dx, dy, dz;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2: return make_sample($urandom, $urandom, $urandom);
            3: begin
                // tiny differences: zero vector, axes and coarse angles
                dx = $urandom_range(0, 16) - 8;
                dy = $urandom_range(0, 16) - 8;
                dz = $urandom_range(0, 16) - 8;
                return make_sample(raw_for(off_x, dx), raw_for(off_y, dy), raw_for(off_z, dz));
            end
            4: begin
                mask = $urandom_range(1, 7);
                return make_sample(mask[0] ? int'(off_x) : int'($urandom),
                                   mask[1] ? int'(off_y) : int'($urandom),
                                   mask[2] ? int'(off_z) : int'($urandom));
            end
            5: begin
                // on the 45 degree boundaries
                m  = $urandom_range(1, 20000);
                dx = rand_sign() * m;
                dy = rand_sign() * m;
                dz = $urandom_range(0, 4000) - 2000;
                return make_sample(raw_for(off_x, dx), raw_for(off_y, dy), raw_for(off_z, dz));
            end
            6: begin
                // exactly on the first fine tangent, either side of the octant
                if ($urandom_range(0, 1) == 1) begin
                    dx = rand_sign() * 16384;
                    dy = rand_sign() * 3259;
                end else begin
                    dx = rand_sign() * 3259;
                    dy = rand_sign() * 16384;
                end
                dz = $urandom_range(0, 2000) - 1000;
                return make_sample(raw_for(off_x, dx), raw_for(off_y, dy), raw_for(off_z, dz));
            end
            default:
                return direction_sample(PI * rand01() - PI / 2.0, 2.0 * PI * rand01() - PI,
                                        50.0 + 30000.0 * rand01());
        endcase
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic send_item(input t_in_item it);
        int gap;
        if (tx_bursty && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0) burst_left--;
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        expected_bins.push_back(predict_bin(it));
        n_items++;
        if (it.action == ACT_CLEAR) n_clears++;
    endtask

    task automatic send_sample(input int x, input int y, input int z);
        send_item(make_sample(x, y, z));
    endtask

    task automatic send_clear();
        t_in_item it;
        it = '0;
        it.action = ACT_CLEAR;
        it.mag_x  = 16'($urandom);
        it.mag_y  = 16'($urandom);
        it.mag_z  = 16'($urandom);
        send_item(it);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_bins.size() != 0) @(posedge clk);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr,
                             input logic signed [SAMPLE_WIDTH-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {{(APB_DW-SAMPLE_WIDTH){value[SAMPLE_WIDTH-1]}}, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr)
            REG_OFFSET_X: off_x = value;
            REG_OFFSET_Y: off_y = value;
            REG_OFFSET_Z: off_z = value;
            default: ;
        endcase
        n_writes++;
    endtask

    // only called with the block idle
    task automatic set_offsets(input int x, input int y, input int z);
        apb_write(REG_OFFSET_X, x[SAMPLE_WIDTH-1:0]);
        apb_write(REG_OFFSET_Y, y[SAMPLE_WIDTH-1:0]);
        apb_write(REG_OFFSET_Z, z[SAMPLE_WIDTH-1:0]);
    endtask

    // ------------------------------------------------------------------
    // receiver, checker, watchdog
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rx_hold_req > 0) begin
            hold_left   = rx_hold_req;
            rx_hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (!rx_stalls) begin
            out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 40);
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            field_errors++;
            if (field_errors <= REPORT_CAP)
                $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endtask

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_bins.size() == 0) begin
                stray_count++;
                $error("result transfer with nothing expected: lat %0d lon %0d count %0d",
                       out_item.lat_bin, out_item.lon_bin, out_item.occupied_count);
            end else begin
                want = expected_bins.pop_front();
                n_checked++;
                check_field("lat_bin", want.lat_bin, out_item.lat_bin);
                check_field("lon_bin", want.lon_bin, out_item.lon_bin);
                check_field("newly_occupied", want.newly_occupied, out_item.newly_occupied);
                check_field("occupied_count", want.occupied_count, out_item.occupied_count);
                check_field("coverage_centipercent", want.coverage_centipercent,
                            out_item.coverage_centipercent);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_bins.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed_axes();
        set_offsets(0, 0, 0);
        send_sample(0, 0, 0);              // zero vector
        send_sample(0, 0, 0);              // same bin again, not new
        send_sample(1000, 0, 0);
        send_sample(-1000, 0, 0);          // negative x axis, mapped to last bin
        send_sample(0, 1000, 0);
        send_sample(0, -1000, 0);
        send_sample(0, 0, 32767);          // no horizontal part
        send_sample(0, 0, -32768);
        send_sample(32767, 32767, 32767);
        send_sample(-32768, -32768, -32768);
        send_sample(32767, -32768, 0);
        send_sample(-32768, 32767, -1);
        send_sample(1000, 1000, 5);        // on the diagonal boundary
        send_sample(-1000, 1000, -5);
        send_sample(16384, 3259, 0);       // on the first tangent boundary
        send_sample(-16384, -3259, 100);
        send_clear();
        send_sample(1, 1, 1);
        send_sample(-1, 0, 0);
        wait_drained();
    endtask

    task automatic test_wide_differences();
        set_offsets(-32768, 32767, -32768);
        send_sample(32767, -32768, 32767);
        send_sample(-32768, 32767, -32768); // differences cancel to zero
        send_sample(-32768, -32768, 0);
        wait_drained();
        set_offsets(32767, -32768, 32767);
        send_sample(-32768, 32767, -32768);
        send_sample(32767, -32768, 32767);
        send_clear();
        wait_drained();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_offsets(0, 0, 0);
                1: set_offsets(32767, -32768, 32767);
                2: set_offsets(-32768, 32767, -32768);
                4: set_offsets($urandom_range(0, 1000) - 500, $urandom_range(0, 1000) - 500,
                               $urandom_range(0, 1000) - 500);
                default: set_offsets($urandom, $urandom, $urandom);
            endcase
            rx_stalls = (phase != 2);
            tx_bursty = (phase != 3);
            for (int n = 0; n < 70; n++) begin
                if ($urandom_range(0, 39) == 0)
                    send_clear();
                else
                    send_item(random_sample());
                // sender waits for the pipe to empty mid-stream
                if (phase == 4 && n == 35) wait_drained();
            end
            wait_drained();
        end
        rx_stalls = 1'b1;
        tx_bursty = 1'b1;
    endtask

    task automatic test_output_backpressure();
        rx_stalls   = 1'b0;
        tx_bursty   = 1'b0;
        rx_hold_req = 600;
        for (int n = 0; n < 16; n++) send_item(random_sample());
        wait_drained();
        rx_stalls = 1'b1;
        tx_bursty = 1'b1;
    endtask

    // aims one sample at the center of every bin still empty
    task automatic test_full_coverage();
        real theta, phi;
        set_offsets(300, -200, 150);
        for (int lat = 0; lat < LAT_BINS; lat++) begin
            for (int lon = 0; lon < LON_BINS; lon++) begin
                if (!occ_map[lat * LON_BINS + lon]) begin
                    theta = -PI / 2.0 + ($itor(lat) + 0.5) * PI / $itor(LAT_BINS);
                    phi   = -PI + ($itor(lon) + 0.5) * 2.0 * PI / $itor(LON_BINS);
                    send_item(direction_sample(theta, phi, 20000.0));
                end
            end
        end
        for (int n = 0; n < 6; n++) send_item(random_sample());
        send_clear();
        send_sample(300, -200, 150);
        wait_drained();
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_axes();
        test_wide_differences();
        test_random_traffic();
        test_output_backpressure();
        test_full_coverage();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d input transfers (%0d clears) and %0d offset writes",
                 n_items, n_clears, n_writes);
        $display("checked %0d results, peak occupancy %0d of %0d bins",
                 n_checked, peak_count, TOTAL_BINS);
        if (field_errors == 0 && stray_count == 0 && expected_bins.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
